// File: sv/subleq_processor_core_macros.svh
// assertion helpers used by the core's top-level rtl file
`ifndef SUBLEQ_PROCESSOR_CORE_MACROS_SVH
`define SUBLEQ_PROCESSOR_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SLQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define SLQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/slq_pkg.sv
`default_nettype none
package slq_pkg;

    localparam int SLQ_WORD_W    = 16;
    localparam int SLQ_MEM_DEPTH = 65536;
    localparam int SLQ_RESET_PC  = 3;
    localparam int SLQ_STEP_W    = 5;

    typedef logic [SLQ_STEP_W-1:0] t_step;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_SETPC = 2'd2,
        KIND_EXEC  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ASEL_IN,
        ASEL_PC,
        ASEL_PC1,
        ASEL_PC2,
        ASEL_A,
        ASEL_B
    } t_asel;

    typedef enum logic [2:0] {
        LD_NONE,
        LD_A,
        LD_B,
        LD_C,
        LD_VA,
        LD_DIFF
    } t_ld;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_DISPATCH,
        JMP_GOTO,
        JMP_IF_HALT,
        JMP_EMIT
    } t_jmp;

    typedef struct packed {
        t_asel asel;
        logic  mod_start;
        logic  wait_mod;
        logic  mem_rd;
        logic  mem_wr;
        logic  wsel_diff;
        t_ld   ld;
        logic  pc_set_in;
        logic  pc_branch;
        t_jmp  jmp;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic halted;
        logic mod_busy;
        logic out_free;
        logic clr_busy;
    } t_seq_stat;

    localparam t_step ST_IDLE = 5'd0;
    localparam t_step ST_W0   = 5'd1;
    localparam t_step ST_W1   = 5'd2;
    localparam t_step ST_R0   = 5'd3;
    localparam t_step ST_R1   = 5'd4;
    localparam t_step ST_P0   = 5'd5;
    localparam t_step ST_E0   = 5'd6;
    localparam t_step ST_E1   = 5'd7;
    localparam t_step ST_E2   = 5'd8;
    localparam t_step ST_E3   = 5'd9;
    localparam t_step ST_E4   = 5'd10;
    localparam t_step ST_E5   = 5'd11;
    localparam t_step ST_E6   = 5'd12;
    localparam t_step ST_E7   = 5'd13;
    localparam t_step ST_E8   = 5'd14;
    localparam t_step ST_E9   = 5'd15;
    localparam t_step ST_E10  = 5'd16;
    localparam t_step ST_E11  = 5'd17;
    localparam t_step ST_E12  = 5'd18;
    localparam t_step ST_FIN  = 5'd19;

    function automatic t_step slq_entry(input t_kind kind);
        t_step s;
        case (kind)
            KIND_WRITE: s = ST_W0;
            KIND_READ:  s = ST_R0;
            KIND_SETPC: s = ST_P0;
            KIND_EXEC:  s = ST_E0;
            default:    s = ST_IDLE;
        endcase
        return s;
    endfunction

    // control store
    function automatic t_ctrl slq_ucode(input t_step step);
        t_ctrl c;
        c        = '0;
        c.asel   = ASEL_IN;
        c.ld     = LD_NONE;
        c.jmp    = JMP_NEXT;
        c.target = ST_IDLE;
        case (step)
            ST_IDLE: c.jmp = JMP_DISPATCH;
            ST_W0: begin
                c.asel = ASEL_IN; c.mod_start = 1'b1;
            end
            ST_W1: begin
                c.wait_mod = 1'b1; c.mem_wr = 1'b1;
                c.jmp = JMP_GOTO; c.target = ST_FIN;
            end
            ST_R0: begin
                c.asel = ASEL_IN; c.mod_start = 1'b1;
            end
            ST_R1: begin
                c.wait_mod = 1'b1; c.mem_rd = 1'b1;
                c.jmp = JMP_GOTO; c.target = ST_FIN;
            end
            ST_P0: begin
                c.pc_set_in = 1'b1; c.jmp = JMP_GOTO; c.target = ST_FIN;
            end
            ST_E0: begin
                c.jmp = JMP_IF_HALT; c.target = ST_FIN;
            end
            ST_E1: begin
                c.asel = ASEL_PC; c.mod_start = 1'b1;
            end
            ST_E2: begin
                c.wait_mod = 1'b1; c.mem_rd = 1'b1;
            end
            ST_E3: begin
                c.ld = LD_A; c.asel = ASEL_PC1; c.mod_start = 1'b1;
            end
            ST_E4: begin
                c.wait_mod = 1'b1; c.mem_rd = 1'b1;
            end
            ST_E5: begin
                c.ld = LD_B; c.asel = ASEL_PC2; c.mod_start = 1'b1;
            end
            ST_E6: begin
                c.wait_mod = 1'b1; c.mem_rd = 1'b1;
            end
            ST_E7: begin
                c.ld = LD_C; c.asel = ASEL_A; c.mod_start = 1'b1;
            end
            ST_E8: begin
                c.wait_mod = 1'b1; c.mem_rd = 1'b1;
            end
            ST_E9: begin
                c.ld = LD_VA; c.asel = ASEL_B; c.mod_start = 1'b1;
            end
            ST_E10: begin
                c.wait_mod = 1'b1; c.mem_rd = 1'b1;
            end
            ST_E11: c.ld = LD_DIFF;
            ST_E12: begin
                c.mem_wr = 1'b1; c.wsel_diff = 1'b1; c.pc_branch = 1'b1;
            end
            ST_FIN: begin
                c.jmp = JMP_EMIT; c.target = ST_IDLE;
            end
            default: begin
                c.jmp = JMP_GOTO; c.target = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// File: sv/slq_addr_mod.sv
`default_nettype none
module slq_addr_mod #(
    parameter int MEM_DEPTH = slq_pkg::SLQ_MEM_DEPTH
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [slq_pkg::SLQ_WORD_W-1:0] i_addr,
    output logic                         o_busy,
    output logic [$clog2(MEM_DEPTH)-1:0] o_idx
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int WW = slq_pkg::SLQ_WORD_W;

    if ((MEM_DEPTH & (MEM_DEPTH - 1)) == 0) begin : g_pow2
        logic [AW-1:0] r_idx;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_idx <= '0;
            end else if (i_start) begin
                r_idx <= i_addr[AW-1:0];
            end
        end

        assign o_busy = 1'b0;
        assign o_idx  = r_idx;
    end else begin : g_iter
        // restoring reduction, one shifted depth per cycle
        localparam int KMAX = WW - AW;
        localparam int KW   = $clog2(KMAX + 2);

        logic [WW-1:0] r_rem;
        logic [KW-1:0] r_k;
        logic          r_busy;
        logic [WW:0]   w_dsh;

        assign w_dsh = (WW + 1)'(MEM_DEPTH) << r_k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy <= 1'b0;
            end else if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == '0) begin
                r_busy <= 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_rem <= i_addr;
                r_k   <= KW'(KMAX);
            end else if (r_busy) begin
                if ({1'b0, r_rem} >= w_dsh) begin
                    r_rem <= r_rem - w_dsh[WW-1:0];
                end
                if (r_k != '0) begin
                    r_k <= r_k - 1'b1;
                end
            end
        end

        assign o_busy = r_busy;
        assign o_idx  = r_rem[AW-1:0];
    end

endmodule
`default_nettype wire

// File: sv/slq_word_mem.sv
`default_nettype none
module slq_word_mem #(
    parameter int MEM_DEPTH = slq_pkg::SLQ_MEM_DEPTH
) (
    input  wire                           i_clk,
    input  wire                           i_we,
    input  wire [$clog2(MEM_DEPTH)-1:0]   i_waddr,
    input  wire [slq_pkg::SLQ_WORD_W-1:0] i_wdata,
    input  wire                           i_re,
    input  wire [$clog2(MEM_DEPTH)-1:0]   i_raddr,
    output logic [slq_pkg::SLQ_WORD_W-1:0] o_rdata
);

    logic [slq_pkg::SLQ_WORD_W-1:0] r_mem [MEM_DEPTH];
    logic [slq_pkg::SLQ_WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: sv/slq_sequencer.sv
`default_nettype none
module slq_sequencer (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  slq_pkg::t_kind     i_kind,
    input  slq_pkg::t_seq_stat i_stat,
    output logic               o_in_ready,
    output slq_pkg::t_ctrl     o_ctrl,
    output logic               o_act,
    output logic               o_emit
);

    slq_pkg::t_step r_step;
    slq_pkg::t_step n_step;
    slq_pkg::t_ctrl w_ctrl;
    logic           w_fire;

    assign w_ctrl     = slq_pkg::slq_ucode(r_step);
    assign o_in_ready = (r_step == slq_pkg::ST_IDLE) && !i_stat.clr_busy;
    assign w_fire     = i_in_valid && o_in_ready;
    // a wait step holds until the address unit is done
    assign o_act      = !(w_ctrl.wait_mod && i_stat.mod_busy);
    assign o_emit     = (w_ctrl.jmp == slq_pkg::JMP_EMIT) && i_stat.out_free;
    assign o_ctrl     = w_ctrl;

    always_comb begin
        n_step = r_step;
        case (w_ctrl.jmp)
            slq_pkg::JMP_NEXT: begin
                if (o_act) n_step = r_step + 1'b1;
            end
            slq_pkg::JMP_DISPATCH: begin
                if (w_fire) n_step = slq_pkg::slq_entry(i_kind);
            end
            slq_pkg::JMP_GOTO: begin
                if (o_act) n_step = w_ctrl.target;
            end
            slq_pkg::JMP_IF_HALT: begin
                n_step = i_stat.halted ? w_ctrl.target : r_step + 1'b1;
            end
            slq_pkg::JMP_EMIT: begin
                if (i_stat.out_free) n_step = w_ctrl.target;
            end
            default: n_step = slq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= slq_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
`default_nettype wire

// File: sv/subleq_processor_core.sv
// 16-bit subleq core with private word memory. Each input item is one command (tuser kind):
// write a word, read a word, set the start pc, or execute one instruction; each yields one
// result item with read data, the pc after the command and a halted flag (pc is zero).
// Commands run one at a time under a microcoded sequencer driving a memory with one write
// port and one read port (one read or one write per cycle) and one address reduction unit.
// With MEM_DEPTH a power of two addresses wrap for free; otherwise each memory access
// waits on a shift-subtract reduction of its address (five per instruction). After reset
// the memory is zeroed one word per cycle, with s_axis_tready low until the sweep ends. A
// finished result waits in an output register while the next item is taken.
`default_nettype none
`include "subleq_processor_core_macros.svh"
module subleq_processor_core #(
    parameter int MEM_DEPTH = slq_pkg::SLQ_MEM_DEPTH,
    parameter int RESET_PC  = slq_pkg::SLQ_RESET_PC
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,  // address, data
    input  wire  [1:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,  // read_data, program_counter
    output logic [0:0]  m_axis_tuser   // halted
);

    localparam int WW = slq_pkg::SLQ_WORD_W;
    localparam int AW = $clog2(MEM_DEPTH);

    slq_pkg::t_ctrl     w_ctrl;
    slq_pkg::t_seq_stat w_stat;
    logic               w_act;
    logic               w_emit;
    logic               w_fire;
    logic               w_mod_busy;
    logic [AW-1:0]      w_idx;
    logic [WW-1:0]      w_addr;
    logic [WW-1:0]      w_rdata;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [WW-1:0]      w_wdata;

    slq_pkg::t_kind r_kind;
    logic [WW-1:0]  r_in_addr;
    logic [WW-1:0]  r_in_data;
    logic [WW-1:0]  r_pc;
    logic [WW-1:0]  r_a;
    logic [WW-1:0]  r_b;
    logic [WW-1:0]  r_c;
    logic [WW-1:0]  r_va;
    logic [WW-1:0]  r_diff;
    logic           r_clr_busy;
    logic [AW-1:0]  r_clr_idx;
    logic           r_out_valid;
    logic [WW-1:0]  r_out_rd;
    logic [WW-1:0]  r_out_pc;
    logic           r_out_halt;

    assign w_stat.halted   = (r_pc == '0);
    assign w_stat.mod_busy = w_mod_busy;
    assign w_stat.out_free = !r_out_valid || m_axis_tready;
    assign w_stat.clr_busy = r_clr_busy;

    slq_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_kind     (slq_pkg::t_kind'(s_axis_tuser)),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_ctrl     (w_ctrl),
        .o_act      (w_act),
        .o_emit     (w_emit)
    );

    assign w_fire = s_axis_tvalid && s_axis_tready;

    always_comb begin
        case (w_ctrl.asel)
            slq_pkg::ASEL_IN:  w_addr = r_in_addr;
            slq_pkg::ASEL_PC:  w_addr = r_pc;
            slq_pkg::ASEL_PC1: w_addr = r_pc + 16'd1;
            slq_pkg::ASEL_PC2: w_addr = r_pc + 16'd2;
            slq_pkg::ASEL_A:   w_addr = r_a;
            slq_pkg::ASEL_B:   w_addr = r_b;
            default:           w_addr = r_in_addr;
        endcase
    end

    slq_addr_mod #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctrl.mod_start),
        .i_addr  (w_addr),
        .o_busy  (w_mod_busy),
        .o_idx   (w_idx)
    );

    assign w_we    = r_clr_busy || (w_ctrl.mem_wr && w_act);
    assign w_waddr = r_clr_busy ? r_clr_idx : w_idx;
    assign w_wdata = r_clr_busy ? '0 : (w_ctrl.wsel_diff ? r_diff : r_in_data);

    slq_word_mem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_ctrl.mem_rd && w_act),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    // zeroing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == AW'(MEM_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_kind    <= slq_pkg::t_kind'(s_axis_tuser);
            r_in_addr <= s_axis_tdata[15:0];
            r_in_data <= s_axis_tdata[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        case (w_ctrl.ld)
            slq_pkg::LD_NONE: ;
            slq_pkg::LD_A:    r_a    <= w_rdata;
            slq_pkg::LD_B:    r_b    <= w_rdata;
            slq_pkg::LD_C:    r_c    <= w_rdata;
            slq_pkg::LD_VA:   r_va   <= w_rdata;
            slq_pkg::LD_DIFF: r_diff <= w_rdata - r_va;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= WW'(RESET_PC);
        end else if (w_ctrl.pc_set_in) begin
            r_pc <= r_in_addr;
        end else if (w_ctrl.pc_branch) begin
            // signed greater than zero: nonzero, sign clear
            r_pc <= (r_diff != '0 && !r_diff[WW-1]) ? r_pc + 16'd3 : r_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_rd   <= (r_kind == slq_pkg::KIND_READ) ? w_rdata : '0;
            r_out_pc   <= r_pc;
            r_out_halt <= (r_pc == '0);
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {r_out_pc, r_out_rd};
    assign m_axis_tuser[0] = r_out_halt;

    `SLQ_ASSERT_IMPL(a_no_accept_in_clear, r_clr_busy, !s_axis_tready, "item accepted during clear")
    `SLQ_ASSERT_IMPL(a_mod_start_idle, w_ctrl.mod_start, !w_mod_busy, "address unit restarted busy")
    `SLQ_ASSERT_NEXT(a_pc_only_by_ucode, 1'b1, $stable(r_pc) || $past(w_ctrl.pc_set_in || w_ctrl.pc_branch), "pc changed outside set or branch step")
    `SLQ_ASSERT_NEXT(a_clear_ends, r_clr_busy && r_clr_idx == AW'(MEM_DEPTH - 1), !r_clr_busy, "clear sweep overran")

endmodule
`default_nettype wire
